/* rtl/r2fft_pkg.sv */
package r2fft_pkg;

    localparam int TW_GRID = 4096;
    localparam int SAMP_W = 16;
    localparam int MAG_W = 22;
    localparam logic [MAG_W-1:0] MAG_MAX = 22'd4194303;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic signed [SAMP_W-1:0] wr;
        logic signed [SAMP_W-1:0] wi;
    } t_tw;

    function automatic logic [SAMP_W-1:0] q30_to_q15(input longint v);
        longint q;
        begin
            if (v <= 0) begin
                q = 0;
            end else begin
                q = (v + 16384) >>> 15;
                if (q > 32767) begin
                    q = 32767;
                end
            end
            return q[SAMP_W-1:0];
        end
    endfunction

    // cos and sin of t*2*pi/4096 for t up to one octant, taylor series in q30
    function automatic logic [2*SAMP_W-1:0] octant(input logic [10:0] t);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] ts;
        logic [63:0] tc;
        longint sv;
        longint cv;
        begin
            a = (64'(t) * PI_Q30 + 64'd1024) >> 11;
            a2 = (a * a) >> 30;
            ts = a;
            tc = 64'd1 << 30;
            sv = longint'(a);
            cv = longint'(tc);
            ts = ((ts * a2) >> 30) / 64'd6;
            tc = ((tc * a2) >> 30) / 64'd2;
            sv = sv - longint'(ts);
            cv = cv - longint'(tc);
            ts = ((ts * a2) >> 30) / 64'd20;
            tc = ((tc * a2) >> 30) / 64'd12;
            sv = sv + longint'(ts);
            cv = cv + longint'(tc);
            ts = ((ts * a2) >> 30) / 64'd42;
            tc = ((tc * a2) >> 30) / 64'd30;
            sv = sv - longint'(ts);
            cv = cv - longint'(tc);
            ts = ((ts * a2) >> 30) / 64'd72;
            tc = ((tc * a2) >> 30) / 64'd56;
            sv = sv + longint'(ts);
            cv = cv + longint'(tc);
            ts = ((ts * a2) >> 30) / 64'd110;
            tc = ((tc * a2) >> 30) / 64'd90;
            sv = sv - longint'(ts);
            cv = cv - longint'(tc);
            ts = ((ts * a2) >> 30) / 64'd156;
            tc = ((tc * a2) >> 30) / 64'd132;
            sv = sv + longint'(ts);
            cv = cv + longint'(tc);
            return {q30_to_q15(cv), q30_to_q15(sv)};
        end
    endfunction

    function automatic t_tw tw_calc(input logic [11:0] r);
        logic [1:0] q;
        logic [9:0] t;
        logic [2*SAMP_W-1:0] cs;
        logic signed [SAMP_W-1:0] c;
        logic signed [SAMP_W-1:0] s;
        t_tw w;
        begin
            q = r[11:10];
            t = r[9:0];
            if (t <= 10'd512) begin
                cs = octant({1'b0, t});
                c = cs[2*SAMP_W-1:SAMP_W];
                s = cs[SAMP_W-1:0];
            end else begin
                cs = octant(11'd1024 - {1'b0, t});
                s = cs[2*SAMP_W-1:SAMP_W];
                c = cs[SAMP_W-1:0];
            end
            case (q)
                2'd0: begin
                    w.wr = c;
                    w.wi = s;
                end
                2'd1: begin
                    w.wr = -s;
                    w.wi = c;
                end
                2'd2: begin
                    w.wr = -c;
                    w.wi = -s;
                end
                default: begin
                    w.wr = s;
                    w.wi = -c;
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/radix2_fft_magnitude.sv */
// Magnitude spectrum of one frame of up to POINTS complex Q1.15 samples. Samples enter
// one per cycle into a single bin memory (real and imaginary packed in one word, one
// read and one write port) until frame_end or a full frame; the length is rounded up
// to a power of two n and padded with zeros, the entries are put in bit-reversed order,
// then the radix-2 stages run in place, (n/2)*log2(n) butterflies, with both legs of
// each butterfly read and written through the one memory port. Each bin then takes a
// memory read, two squares and a square root that yields one result bit per cycle, and
// waits out any output stall. No input is taken from the close of a frame until its
// last bin has been transferred.
module radix2_fft_magnitude
    import r2fft_pkg::*;
#(
    parameter int POINTS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [SAMP_W-1:0] i_sample_real,
    input  logic signed [SAMP_W-1:0] i_sample_imag,
    input  logic                     i_frame_end,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [MAG_W-1:0]         o_magnitude,
    output logic                     o_bin_last
);

    localparam int LGD = $clog2(POINTS);
    localparam int D = 1 << LGD;
    localparam int W = 18 + LGD;
    localparam int AW = LGD;
    localparam int KW = LGD + 1;
    localparam int LW = $clog2(LGD + 1);
    localparam int SW = 2 * W;
    localparam int ITW = $clog2(W + 1);
    localparam int TWD = (D < 4) ? 2 : D / 2;
    localparam int TWA = $clog2(TWD);
    localparam int RND_HALF = 16384;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_PAD    = 4'd1;
    localparam logic [3:0] S_SW_CHK = 4'd2;
    localparam logic [3:0] S_SW_RDJ = 4'd3;
    localparam logic [3:0] S_SW_WRI = 4'd4;
    localparam logic [3:0] S_SW_WRJ = 4'd5;
    localparam logic [3:0] S_BF_RDQ = 4'd6;
    localparam logic [3:0] S_BF_RDP = 4'd7;
    localparam logic [3:0] S_BF_MUL = 4'd8;
    localparam logic [3:0] S_BF_WRQ = 4'd9;
    localparam logic [3:0] S_BF_WRP = 4'd10;
    localparam logic [3:0] S_O_RD   = 4'd11;
    localparam logic [3:0] S_O_SQ   = 4'd12;
    localparam logic [3:0] S_O_SUM  = 4'd13;
    localparam logic [3:0] S_O_SQRT = 4'd14;
    localparam logic [3:0] S_O_OUT  = 4'd15;

    function automatic logic [LW-1:0] ceil_lg(input logic [KW-1:0] len);
        logic [LW-1:0] lg;
        begin
            lg = '0;
            for (int l = 0; l < LGD; l++) begin
                if ((KW'(1) << l) < len) begin
                    lg = LW'(l + 1);
                end
            end
            return lg;
        end
    endfunction

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        begin
            for (int b = 0; b < AW; b++) begin
                r[AW-1-b] = v[b];
            end
            return r;
        end
    endfunction

    logic [SW-1:0]  mem [D];

    logic [3:0]     r_state;
    logic [KW-1:0]  r_cnt;
    logic [KW-1:0]  r_k;
    logic [LW-1:0]  r_lg;
    logic [LW-1:0]  r_s;
    logic [AW-1:0]  r_b;
    logic [SW-1:0]  r_rd;
    logic [SW-1:0]  r_a;
    logic [SW-1:0]  r_b_dat;
    logic [SW-1:0]  r_t;
    t_tw            r_tw;
    logic signed [W+SAMP_W-1:0] r_p_rr;
    logic signed [W+SAMP_W-1:0] r_p_ii;
    logic signed [W+SAMP_W-1:0] r_p_ri;
    logic signed [W+SAMP_W-1:0] r_p_ir;
    logic [SW-1:0]  r_sq_re;
    logic [SW-1:0]  r_sq_im;
    logic [SW-1:0]  r_v;
    logic [SW-1:0]  r_res;
    logic [SW-1:0]  r_bit;
    logic [ITW-1:0] r_it;

    t_tw            w_tw [TWD];
    logic [KW-1:0]  w_cnt_inc;
    logic [KW-1:0]  w_n;
    logic [KW-1:0]  w_half;
    logic [AW-1:0]  w_rev;
    logic [AW-1:0]  w_h;
    logic [AW-1:0]  w_i;
    logic [AW-1:0]  w_p;
    logic [AW-1:0]  w_q;
    logic [AW-1:0]  w_twi_full;
    logic [TWA-1:0] w_tw_idx;
    logic signed [W-1:0] w_br;
    logic signed [W-1:0] w_bi;
    logic signed [W-1:0] w_ar;
    logic signed [W-1:0] w_ai;
    logic signed [W+SAMP_W:0] w_sr;
    logic signed [W+SAMP_W:0] w_si;
    logic signed [W+SAMP_W:0] w_sr_sh;
    logic signed [W+SAMP_W:0] w_si_sh;
    logic signed [W-1:0] w_tr;
    logic signed [W-1:0] w_ti;
    logic signed [W-1:0] w_ptr;
    logic signed [W-1:0] w_pti;
    logic signed [W-1:0] w_re;
    logic signed [W-1:0] w_im;
    logic [SW-1:0]  w_try;
    logic           w_last;

    for (genvar g = 0; g < TWD; g++) begin : g_tw
        assign w_tw[g] = tw_calc(12'(g * (TW_GRID / D)));
    end

    assign w_cnt_inc = r_cnt + KW'(1);
    assign w_n = KW'(1) << r_lg;
    assign w_half = w_n >> 1;
    assign w_rev = bit_rev(r_k[AW-1:0]) >> (LGD - int'(r_lg));

    // butterfly legs: insert a zero at bit s-1 of the butterfly count
    assign w_h = AW'(1) << (r_s - LW'(1));
    assign w_i = r_b & (w_h - AW'(1));
    assign w_p = ((r_b >> (r_s - LW'(1))) << r_s) | w_i;
    assign w_q = w_p | w_h;
    assign w_twi_full = w_i << (LGD - int'(r_s));
    assign w_tw_idx = w_twi_full[TWA-1:0];

    assign w_br = r_b_dat[SW-1:W];
    assign w_bi = r_b_dat[W-1:0];
    assign w_ar = r_a[SW-1:W];
    assign w_ai = r_a[W-1:0];

    // twiddle product rounded once, half up
    assign w_sr = (W+SAMP_W+1)'(r_p_rr) - (W+SAMP_W+1)'(r_p_ii)
                + (W+SAMP_W+1)'(RND_HALF);
    assign w_si = (W+SAMP_W+1)'(r_p_ri) + (W+SAMP_W+1)'(r_p_ir)
                + (W+SAMP_W+1)'(RND_HALF);
    assign w_sr_sh = w_sr >>> 15;
    assign w_si_sh = w_si >>> 15;
    assign w_tr = w_sr_sh[W-1:0];
    assign w_ti = w_si_sh[W-1:0];
    assign w_ptr = r_t[SW-1:W];
    assign w_pti = r_t[W-1:0];

    assign w_re = r_rd[SW-1:W];
    assign w_im = r_rd[W-1:0];
    assign w_try = r_res + r_bit;
    assign w_last = (r_k == w_n - KW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        mem[r_cnt[AW-1:0]] <= {{(W-SAMP_W){i_sample_real[SAMP_W-1]}},
                                               i_sample_real,
                                               {(W-SAMP_W){i_sample_imag[SAMP_W-1]}},
                                               i_sample_imag};
                        if (i_frame_end || w_cnt_inc == KW'(POINTS)) begin
                            r_k <= w_cnt_inc;
                            r_lg <= ceil_lg(w_cnt_inc);
                            r_cnt <= '0;
                            r_state <= S_PAD;
                        end else begin
                            r_cnt <= w_cnt_inc;
                        end
                    end
                end
                S_PAD: begin
                    if (r_k == w_n) begin
                        r_k <= '0;
                        r_state <= S_SW_CHK;
                    end else begin
                        mem[r_k[AW-1:0]] <= '0;
                        r_k <= r_k + KW'(1);
                    end
                end
                S_SW_CHK: begin
                    if (r_k == w_n) begin
                        r_k <= '0;
                        r_s <= LW'(1);
                        r_b <= '0;
                        if (r_lg == '0) begin
                            r_state <= S_O_RD;
                        end else begin
                            r_state <= S_BF_RDQ;
                        end
                    end else if (w_rev > r_k[AW-1:0]) begin
                        r_rd <= mem[r_k[AW-1:0]];
                        r_state <= S_SW_RDJ;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_SW_RDJ: begin
                    r_a <= r_rd;
                    r_rd <= mem[w_rev];
                    r_state <= S_SW_WRI;
                end
                S_SW_WRI: begin
                    mem[r_k[AW-1:0]] <= r_rd;
                    r_state <= S_SW_WRJ;
                end
                S_SW_WRJ: begin
                    mem[w_rev] <= r_a;
                    r_k <= r_k + KW'(1);
                    r_state <= S_SW_CHK;
                end
                S_BF_RDQ: begin
                    r_rd <= mem[w_q];
                    r_tw <= w_tw[w_tw_idx];
                    r_state <= S_BF_RDP;
                end
                S_BF_RDP: begin
                    r_b_dat <= r_rd;
                    r_rd <= mem[w_p];
                    r_state <= S_BF_MUL;
                end
                S_BF_MUL: begin
                    r_a <= r_rd;
                    r_p_rr <= w_br * r_tw.wr;
                    r_p_ii <= w_bi * r_tw.wi;
                    r_p_ri <= w_br * r_tw.wi;
                    r_p_ir <= w_bi * r_tw.wr;
                    r_state <= S_BF_WRQ;
                end
                S_BF_WRQ: begin
                    mem[w_q] <= {w_ar - w_tr, w_ai - w_ti};
                    r_t <= {w_tr, w_ti};
                    r_state <= S_BF_WRP;
                end
                S_BF_WRP: begin
                    mem[w_p] <= {w_ar + w_ptr, w_ai + w_pti};
                    r_state <= S_BF_RDQ;
                    if (r_b == AW'(w_half - KW'(1))) begin
                        r_b <= '0;
                        if (r_s == r_lg) begin
                            r_k <= '0;
                            r_state <= S_O_RD;
                        end else begin
                            r_s <= r_s + LW'(1);
                        end
                    end else begin
                        r_b <= r_b + AW'(1);
                    end
                end
                S_O_RD: begin
                    r_rd <= mem[r_k[AW-1:0]];
                    r_state <= S_O_SQ;
                end
                S_O_SQ: begin
                    r_sq_re <= w_re * w_re;
                    r_sq_im <= w_im * w_im;
                    r_state <= S_O_SUM;
                end
                S_O_SUM: begin
                    r_v <= r_sq_re + r_sq_im;
                    r_res <= '0;
                    r_bit <= SW'(1) << (SW - 2);
                    r_it <= '0;
                    r_state <= S_O_SQRT;
                end
                S_O_SQRT: begin
                    // one result bit per cycle
                    if (r_v >= w_try) begin
                        r_v <= r_v - w_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_it <= r_it + ITW'(1);
                    if (r_it == ITW'(W - 1)) begin
                        r_state <= S_O_OUT;
                    end
                end
                S_O_OUT: begin
                    if (!i_stall) begin
                        if (w_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_k <= r_k + KW'(1);
                            r_state <= S_O_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_LOAD);
    assign o_valid = (r_state == S_O_OUT);
    assign o_bin_last = w_last;
    assign o_magnitude = (r_res > SW'(MAG_MAX)) ? MAG_MAX : r_res[MAG_W-1:0];

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && !o_stall))
        else $error("input open while a bin is pending");

    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bin_last && !i_stall) |=> (!o_valid && !o_stall))
        else $error("block did not return to loading after the last bin");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF_RDQ || r_state == S_BF_WRP) |-> (r_s != '0 && r_s <= r_lg))
        else $error("stage counter out of range");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_cnt < KW'(POINTS)))
        else $error("sample count beyond frame size");

endmodule
